// ===== sv/lsrf_pkg.sv =====
// Shared constants and controller/datapath interface types for the square divisor block.
`default_nettype none
package lsrf_pkg;

    // Width of the input value and the derived widths.
    localparam int VALUE_BITS   = 31;
    localparam int ROOT_BITS    = (VALUE_BITS + 1) / 2;
    localparam int SQUARE_BITS  = 2 * ROOT_BITS;
    localparam int COUNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int RESULT_BITS  = 16;
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic start;        // load value and begin the square root
        logic root_step;    // one square root digit
        logic load_cand;    // candidate takes the floor root
        logic square;       // square the candidate, arm the divider
        logic div_step;     // one remainder bit
        logic decr;         // next smaller candidate
        logic load_result;  // write the output register
    } lsrf_cmd_t;

    typedef struct packed {
        logic count_done;   // step counter at its last step
        logic perfect;      // square root left no remainder
        logic rem_zero;     // candidate square divides the value
        logic cand_le1;     // candidate is 0 or 1
    } lsrf_status_t;

endpackage
`default_nettype wire

// ===== sv/lsrf_datapath.sv =====
// Datapath: serial square root, candidate squarer and serial remainder unit.
`default_nettype none
module lsrf_datapath (
    input  wire logic                               aclk,
    input  wire lsrf_pkg::lsrf_cmd_t                cmd,
    input  wire logic [lsrf_pkg::S_TDATA_BITS-1:0]  value_in,
    output lsrf_pkg::lsrf_status_t                  status,
    output logic [lsrf_pkg::RESULT_BITS-1:0]        result
);
    import lsrf_pkg::*;

    logic [VALUE_BITS-1:0]  value_reg,  value_next;
    logic [VALUE_BITS-1:0]  shift_reg,  shift_next;
    logic [SQUARE_BITS-1:0] rad_reg,    rad_next;
    logic [SQUARE_BITS-1:0] res_reg,    res_next;
    logic [SQUARE_BITS-1:0] bit_reg,    bit_next;
    logic [SQUARE_BITS-1:0] sq_reg,     sq_next;
    logic [SQUARE_BITS-1:0] rem_reg,    rem_next;
    logic [ROOT_BITS-1:0]   cand_reg,   cand_next;
    logic [COUNT_BITS-1:0]  cnt_reg,    cnt_next;
    logic [RESULT_BITS-1:0] result_reg, result_next;

    logic [SQUARE_BITS:0]   trial;
    logic [SQUARE_BITS:0]   partial;

    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign partial = {rem_reg, shift_reg[VALUE_BITS-1]};

    always_comb begin
        value_next  = value_reg;
        shift_next  = shift_reg;
        rad_next    = rad_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        cand_next   = cand_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        if (cmd.start) begin
            value_next = value_in[VALUE_BITS-1:0];
            rad_next   = SQUARE_BITS'(value_in[VALUE_BITS-1:0]);
            res_next   = '0;
            bit_next   = {2'b01, {(SQUARE_BITS-2){1'b0}}};
            cnt_next   = COUNT_BITS'(ROOT_BITS - 1);
        end
        if (cmd.root_step) begin
            if ({1'b0, rad_reg} >= trial) begin
                rad_next = rad_reg - trial[SQUARE_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.load_cand) begin
            cand_next = res_reg[ROOT_BITS-1:0];
        end
        if (cmd.square) begin
            sq_next    = cand_reg * cand_reg;
            rem_next   = '0;
            shift_next = value_reg;
            cnt_next   = COUNT_BITS'(VALUE_BITS - 1);
        end
        // Restoring division, one quotient bit per cycle; only the remainder is kept.
        if (cmd.div_step) begin
            if (partial >= {1'b0, sq_reg}) begin
                rem_next = partial[SQUARE_BITS-1:0] - sq_reg;
            end else begin
                rem_next = partial[SQUARE_BITS-1:0];
            end
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
        end
        if (cmd.decr) begin
            cand_next = cand_reg - 1'b1;
        end
        if (cmd.load_result) begin
            result_next = (rad_reg == '0) ? '0 : RESULT_BITS'(cand_reg);
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        shift_reg  <= shift_next;
        rad_reg    <= rad_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        cand_reg   <= cand_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign status.count_done = (cnt_reg == '0);
    assign status.perfect    = (rad_reg == '0);
    assign status.rem_zero   = (rem_reg == '0);
    assign status.cand_le1   = (cand_reg <= ROOT_BITS'(1));
    assign result            = result_reg;

endmodule
`default_nettype wire

// ===== sv/lsrf_controller.sv =====
// Controller: sequences the root, candidate search and output handshake.
`default_nettype none
module lsrf_controller (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    input  wire lsrf_pkg::lsrf_status_t  status,
    output lsrf_pkg::lsrf_cmd_t          cmd
);
    import lsrf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ROOT   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_SQUARE = 7'b0001000,
        ST_DIVIDE = 7'b0010000,
        ST_TEST   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.count_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.load_cand = 1'b1;
                state_next    = status.perfect ? ST_FINISH : ST_SQUARE;
            end
            ST_SQUARE: begin
                // A candidate of one always divides, so the search stops there.
                if (status.cand_le1) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.square = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.count_done) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.rem_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.decr   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== sv/largest_square_root_factor.sv =====
// Top level of the largest square divisor root block.
`default_nettype none
// For each request on the s_ channel the block returns the largest i whose square
// divides the value, or 0 when the value is a perfect square (0 and 1 included).
// One request is worked on at a time. It is accepted, the floor square root is found
// digit by digit, and the root is checked; then each candidate is tried from the root
// downward (square, one remainder step per value bit, test), and at last the output
// register is written. The result waits in an output register, so a new request is
// taken while the previous result is still pending.
module largest_square_root_factor (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lsrf_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [30:0] value
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lsrf_pkg::M_TDATA_BITS-1:0]       m_tdata    // [15:0] root_factor
);
    import lsrf_pkg::*;

    lsrf_cmd_t              cmd;
    lsrf_status_t           status;
    logic [RESULT_BITS-1:0] result;

    lsrf_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lsrf_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .value_in (s_tdata),
        .status   (status),
        .result   (result)
    );

    assign m_tdata = M_TDATA_BITS'(result);

endmodule
`default_nettype wire
